// ----- rtl/ospa_pkg.sv -----
package ospa_pkg;

    // Pool geometry.
    localparam int CHUNK_ITEMS  = 16;
    localparam int CHUNK_SLOTS  = 15;
    localparam int BLOCK_ITEMS  = 64;
    localparam int GROUP_BLOCKS = 8;
    localparam int MAX_GROUPS   = 8;

    localparam int TOTAL_BLOCKS = GROUP_BLOCKS * MAX_GROUPS;
    localparam int STORE_DEPTH  = 256;
    localparam int STORE_AW     = 8;
    localparam int CAP_RAW      = CHUNK_ITEMS * (CHUNK_SLOTS + 1);
    localparam int STACK_CAP    = (CAP_RAW > STORE_DEPTH) ? STORE_DEPTH : CAP_RAW;

    // Field and state widths.
    localparam int HANDLE_W = 12;
    localparam int COUNT_W  = 9;
    localparam int BLOCK_W  = 6;
    localparam int FILL_W   = 7;
    localparam int USED_W   = 7;

    typedef enum logic {
        REQ_GET    = 1'b0,
        REQ_RETURN = 1'b1
    } t_req;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FAIL = 1'b1
    } t_status;

    // Handle of a slot: block number times block size plus offset, kept to 12 bits.
    function automatic logic [HANDLE_W-1:0] mk_handle(input logic [BLOCK_W-1:0] blk,
                                                      input logic [FILL_W-1:0] off);
        logic [31:0] sum;
        sum = 32'(blk) * 32'(BLOCK_ITEMS) + 32'(off);
        return sum[HANDLE_W-1:0];
    endfunction

endpackage

// ----- rtl/ospa_ram.sv -----
module ospa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/object_slot_pool_allocator.sv -----
// Channel   Handshake           Word
// input     i_valid / o_ready   i_req_type, i_handle_in
// output    o_valid / i_ready   o_handle_out, o_status
//
// One word is taken per cycle while the result is not stalled. An accepted word passes
// through the input register, then the result register, before its result can leave.
// The free stack lives in a 256-entry RAM; its next top is read every cycle,
// with a bypass for a push to that same entry, so pops run back to back.
// Reset (synchronous, active low) empties the stack and closes all blocks.
// A stalled result holds the input register; the input side stalls only then.
module object_slot_pool_allocator
    import ospa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic [HANDLE_W-1:0] i_handle_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic                o_status
);

    // Input register.
    logic                r_in_valid;
    t_req                r_in_req;
    logic [HANDLE_W-1:0] r_in_handle;

    // Result register.
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    t_status             r_out_status;
    logic [HANDLE_W-1:0] n_out_handle;
    t_status             n_out_status;

    // Allocator state.
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_open, n_open;
    logic [BLOCK_W-1:0]  r_cur, n_cur;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [USED_W-1:0]   r_used, n_used;

    // Stack RAM and read bypass.
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [STORE_AW-1:0] rd_addr;
    logic [HANDLE_W-1:0] rd_data;
    logic                r_byp_hit;
    logic [HANDLE_W-1:0] r_byp_data;
    logic [HANDLE_W-1:0] top;
    logic [COUNT_W-1:0]  next_top_idx;

    logic fire;

    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    assign wr_addr      = r_count[STORE_AW-1:0];
    assign next_top_idx = n_count - COUNT_W'(1);
    assign rd_addr      = next_top_idx[STORE_AW-1:0];
    assign top          = r_byp_hit ? r_byp_data : rd_data;

    ospa_ram #(
        .WIDTH(HANDLE_W),
        .DEPTH(STORE_DEPTH)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(r_in_handle),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        n_count      = r_count;
        n_open       = r_open;
        n_cur        = r_cur;
        n_fill       = r_fill;
        n_used       = r_used;
        n_out_handle = '0;
        n_out_status = ST_OK;
        wr_en        = 1'b0;
        if (fire) begin
            unique case (r_in_req)
                REQ_RETURN: begin
                    if (r_count < COUNT_W'(STACK_CAP)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + COUNT_W'(1);
                    end else begin
                        n_out_status = ST_FAIL;
                    end
                end
                REQ_GET: begin
                    priority if (r_count != '0) begin
                        n_count      = r_count - COUNT_W'(1);
                        n_out_handle = top;
                    end else if (r_open && (r_fill < FILL_W'(BLOCK_ITEMS))) begin
                        n_out_handle = mk_handle(r_cur, r_fill);
                        n_fill       = r_fill + FILL_W'(1);
                    end else if (r_used < USED_W'(TOTAL_BLOCKS)) begin
                        n_cur        = r_used[BLOCK_W-1:0];
                        n_used       = r_used + USED_W'(1);
                        n_open       = 1'b1;
                        n_fill       = FILL_W'(1);
                        n_out_handle = mk_handle(r_used[BLOCK_W-1:0], '0);
                    end else begin
                        n_open       = 1'b0;
                        n_out_status = ST_FAIL;
                    end
                end
                default: begin
                    n_out_status = ST_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_open      <= 1'b0;
            r_cur       <= '0;
            r_fill      <= '0;
            r_used      <= '0;
            r_byp_hit   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_count   <= n_count;
            r_open    <= n_open;
            r_cur     <= n_cur;
            r_fill    <= n_fill;
            r_used    <= n_used;
            r_byp_hit <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_req    <= t_req'(i_req_type);
            r_in_handle <= i_handle_in;
        end
        if (fire) begin
            r_out_handle <= n_out_handle;
            r_out_status <= n_out_status;
        end
        r_byp_data <= r_in_handle;
    end

    assign o_valid      = r_out_valid;
    assign o_handle_out = r_out_handle;
    assign o_status     = r_out_status;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STACK_CAP))
        else $error("free stack count above capacity");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(BLOCK_ITEMS))
        else $error("block fill above block size");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in_req == REQ_GET) && (r_count != '0)
        |=> (r_out_status == ST_OK) && (r_count == $past(r_count) - COUNT_W'(1)))
        else $error("pop from non-empty stack did not succeed");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in_req == REQ_RETURN) && (r_count < COUNT_W'(STACK_CAP))
        |=> (r_count == $past(r_count) + COUNT_W'(1)) && (r_out_status == ST_OK))
        else $error("push to stack with room did not advance count");

    a_no_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_count) && $stable(r_used) && $stable(r_fill))
        else $error("allocator state changed without a word in process");
`endif

endmodule
